### hdl/cli_pkg.sv
// Shared types and constants for the core-local interruptor.
// Holds the input/result word structs, command and decode codes.
// No dependencies.
package cli_pkg;

  // Commands carried in the input word
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_SUPER = 2'd3;

  // Decoded target of an item
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_SOFT  = 3'd1;
  localparam logic [2:0] KIND_MCMP  = 3'd2;
  localparam logic [2:0] KIND_TIME  = 3'd3;
  localparam logic [2:0] KIND_SUPER = 3'd4;

  localparam int          TIMER_REGION_BYTES = 32768;
  localparam logic [63:0] TIME_OFFSET        = 64'h7FF8;
  localparam logic [63:0] RESET_BASE         = 64'h0200_0000;
  localparam int          OUT_BITS           = 4;
  localparam int          HART_IDX_W         = 6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] address;
    logic [63:0] write_data;
    logic [1:0]  hart_select;
  } in_word_t;

  typedef struct packed {
    logic [63:0]         read_data;
    logic [OUT_BITS-1:0] soft_irq_bits;
    logic [OUT_BITS-1:0] machine_timer_irq_bits;
    logic [OUT_BITS-1:0] super_timer_irq_bits;
    logic [63:0]         time_value;
  } out_word_t;

  // Item after address decode
  typedef struct packed {
    logic [1:0]            cmd;
    logic [2:0]            kind;
    logic [HART_IDX_W-1:0] hart;
    logic [63:0]           write_data;
  } dec_t;

endpackage

### hdl/cli_decode.sv
// Address decoder: maps an input word onto a target register and hart.
// Depends on cli_pkg.
module cli_decode #(
  parameter int HARTS             = 4,
  parameter int SOFT_REGION_BYTES = 16384
) (
  input  cli_pkg::in_word_t in_word,
  input  logic [63:0]       base,
  output cli_pkg::dec_t     dec
);
  import cli_pkg::*;

  logic [63:0] off;
  logic [63:0] toff;
  logic        in_soft;
  logic        in_timer;

  // Offset into the device region, wrapping
  assign off      = in_word.address - base;
  assign toff     = off - 64'(SOFT_REGION_BYTES);
  assign in_soft  = off < 64'(SOFT_REGION_BYTES);
  assign in_timer = !in_soft && (off < 64'(SOFT_REGION_BYTES + TIMER_REGION_BYTES));

  // Pick target; out-of-range harts decode as nothing
  always_comb begin
    dec.cmd        = in_word.cmd;
    dec.write_data = in_word.write_data;
    dec.kind       = KIND_NONE;
    dec.hart       = '0;
    case (in_word.cmd)
      CMD_READ, CMD_WRITE: begin
        if (in_soft) begin
          dec.hart = off[2 +: HART_IDX_W];
          if (off[63:2] < 62'(HARTS)) dec.kind = KIND_SOFT;
        end else if (in_timer) begin
          dec.hart = toff[3 +: HART_IDX_W];
          if (toff == TIME_OFFSET) begin
            dec.kind = KIND_TIME;
          end else if (toff[63:3] < 61'(HARTS)) begin
            dec.kind = KIND_MCMP;
          end
        end
      end
      CMD_SUPER: begin
        dec.hart = HART_IDX_W'(in_word.hart_select);
        if (8'(in_word.hart_select) < 8'(HARTS)) dec.kind = KIND_SUPER;
      end
      default: ;
    endcase
  end

endmodule

### hdl/cli_core.sv
// Interruptor state: time counter, per-hart soft bits and compares.
// Applies one decoded item per fire and forms the result word.
// Depends on cli_pkg.
module cli_core #(
  parameter int HARTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  cli_pkg::dec_t      dec,
  output cli_pkg::out_word_t res
);
  import cli_pkg::*;

  localparam int HW = (HARTS > 1) ? $clog2(HARTS) : 1;

  logic [63:0]      time_r, time_nxt;
  logic [HARTS-1:0] soft_r, soft_nxt;
  logic [63:0]      mcmp_r [HARTS];
  logic [63:0]      mcmp_nxt [HARTS];
  logic [63:0]      scmp_r [HARTS];
  logic [63:0]      scmp_nxt [HARTS];
  logic [63:0]      rdata;
  logic [HW-1:0]    idx;

  assign idx = dec.hart[HW-1:0];

  // Apply the item to the state and pick read data
  always_comb begin
    time_nxt = time_r;
    soft_nxt = soft_r;
    mcmp_nxt = mcmp_r;
    scmp_nxt = scmp_r;
    rdata    = '0;
    case (dec.cmd)
      CMD_TICK: time_nxt = time_r + 64'd1;
      CMD_READ: begin
        case (dec.kind)
          KIND_SOFT: rdata = {63'd0, soft_r[idx]};
          KIND_MCMP: rdata = mcmp_r[idx];
          KIND_TIME: rdata = time_r;
          default:   rdata = '0;
        endcase
      end
      CMD_WRITE: begin
        case (dec.kind)
          KIND_SOFT: soft_nxt[idx] = dec.write_data[0];
          KIND_MCMP: mcmp_nxt[idx] = dec.write_data;
          KIND_TIME: time_nxt      = dec.write_data;
          default:   ;
        endcase
      end
      CMD_SUPER: begin
        if (dec.kind == KIND_SUPER) scmp_nxt[idx] = dec.write_data;
      end
      default: ;
    endcase
  end

  // Commit on fire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      soft_r <= '0;
      for (int h = 0; h < HARTS; h++) begin
        mcmp_r[h] <= '0;
        scmp_r[h] <= '1;
      end
    end else if (fire) begin
      time_r <= time_nxt;
      soft_r <= soft_nxt;
      mcmp_r <= mcmp_nxt;
      scmp_r <= scmp_nxt;
    end
  end

  // Pending bits from the updated state; absent harts read as zero
  logic [OUT_BITS-1:0] sbits, mbits, tbits;

  for (genvar h = 0; h < OUT_BITS; h++) begin : g_irq
    if (h < HARTS) begin : g_hart
      assign sbits[h] = soft_nxt[h];
      assign mbits[h] = time_nxt >= mcmp_nxt[h];
      assign tbits[h] = (scmp_nxt[h] != '1) && (time_nxt >= scmp_nxt[h]);
    end else begin : g_none
      assign sbits[h] = 1'b0;
      assign mbits[h] = 1'b0;
      assign tbits[h] = 1'b0;
    end
  end

  always_comb begin
    res.read_data              = rdata;
    res.soft_irq_bits          = sbits;
    res.machine_timer_irq_bits = mbits;
    res.super_timer_irq_bits   = tbits;
    res.time_value             = time_nxt;
  end

endmodule

### hdl/core_local_interruptor.sv
// Core-local interruptor top level: input register, state core, result register.
// Depends on cli_pkg, cli_decode and cli_core.
//
//   port group | direction | handshake        | word
//   in_        | in        | in_valid/ready   | cli_pkg::in_word_t
//   out_       | out       | out_valid/ready  | cli_pkg::out_word_t
//   cfg_       | in        | cfg_we           | 64-bit base address
//
// One word per cycle sustained while out_ready stays high; an accepted word is
// registered in the input stage, then in the result stage, where out_valid rises.
// Both the wide offset compare (decode) and the 64-bit compares against the
// updated time set the per-stage delay.
// rst_n clears both stage valids and the state; base address resets to 0x0200_0000.
// A stalled result holds the input stage; in_ready drops only when both are full.
module core_local_interruptor #(
  parameter int HARTS             = 4,
  parameter int SOFT_REGION_BYTES = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cli_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output cli_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata
);
  import cli_pkg::*;

  logic [63:0] base_addr_r;
  logic        s1_valid_r;
  dec_t        dec_r;
  dec_t        dec_in;
  logic        out_valid_r;
  out_word_t   out_word_r;
  out_word_t   res;
  logic        out_free;
  logic        fire;

  assign out_free  = !out_valid_r || out_ready;
  assign fire      = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Hold the base address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_addr_r <= RESET_BASE;
    end else if (cfg_we) begin
      base_addr_r <= cfg_wdata;
    end
  end

  cli_decode #(
    .HARTS             (HARTS),
    .SOFT_REGION_BYTES (SOFT_REGION_BYTES)
  ) u_decode (
    .in_word (in_word),
    .base    (base_addr_r),
    .dec     (dec_in)
  );

  // Input stage: capture the decoded word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) dec_r <= dec_in;
  end

  cli_core #(
    .HARTS (HARTS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .dec   (dec_r),
    .res   (res)
  );

  // Result stage: advance when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_word_r <= res;
  end

endmodule

### hdl/cli_checker.sv
// Port-level checks for the core-local interruptor, bound to the top level.
// Depends on cli_pkg and core_local_interruptor.
module cli_checker #(
  parameter int HARTS = 4
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cli_pkg::out_word_t out_word
);
  import cli_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input backpressure only comes from a stalled, full result stage
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // Harts that do not exist never raise a pending bit
  a_absent_harts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_word.soft_irq_bits | out_word.machine_timer_irq_bits |
                    out_word.super_timer_irq_bits) >> HARTS) == '0)
    else $error("pending bit for absent hart");

endmodule

bind core_local_interruptor cli_checker #(
  .HARTS (HARTS)
) u_cli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

### tb/sv/testbench.sv
// Self-checking bench for core_local_interruptor: random and directed bus traffic.
// Predicts every result word in a scoreboard class; depends on cli_pkg and the RTL.
`timescale 1ns / 100ps

localparam int HART_COUNT = 4;
localparam int SOFT_BYTES = 16384;

// Scoreboard: mirrors the interruptor state and queues the expected result words
class irq_scoreboard;
  logic [63:0]        base_addr;
  logic [63:0]        time_count;
  bit                 soft_pending [HART_COUNT];
  logic [63:0]        mach_cmp [HART_COUNT];
  logic [63:0]        super_cmp [HART_COUNT];
  cli_pkg::out_word_t expected_words [$];
  int                 mismatch_count;

  function new();
    base_addr = cli_pkg::RESET_BASE;
    time_count = '0;
    mismatch_count = 0;
    for (int h = 0; h < HART_COUNT; h++) begin
      soft_pending[h] = 1'b0;
      mach_cmp[h] = '0;
      super_cmp[h] = '1;
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction

  // Apply one accepted input word and queue the result it must produce
  function void note_word(cli_pkg::in_word_t w);
    cli_pkg::out_word_t want;
    logic [63:0]        off;
    logic [63:0]        slot;
    logic [63:0]        rdata;
    rdata = '0;
    if (w.cmd == cli_pkg::CMD_TICK) begin
      time_count = time_count + 64'd1;
    end else if (w.cmd == cli_pkg::CMD_SUPER) begin
      if (int'(w.hart_select) < HART_COUNT) super_cmp[w.hart_select] = w.write_data;
    end else begin
      off = w.address - base_addr;
      if (off < 64'(SOFT_BYTES)) begin
        // software slots: 4 bytes per hart, only bit 0 is kept
        slot = off >> 2;
        if (slot < 64'(HART_COUNT)) begin
          if (w.cmd == cli_pkg::CMD_WRITE) soft_pending[int'(slot)] = w.write_data[0];
          else rdata = {63'd0, soft_pending[int'(slot)]};
        end
      end else if (off < 64'(SOFT_BYTES + cli_pkg::TIMER_REGION_BYTES)) begin
        // timer region: time counter at its fixed offset, else 8-byte compares
        off = off - 64'(SOFT_BYTES);
        if (off == cli_pkg::TIME_OFFSET) begin
          if (w.cmd == cli_pkg::CMD_WRITE) time_count = w.write_data;
          else rdata = time_count;
        end else begin
          slot = off >> 3;
          if (slot < 64'(HART_COUNT)) begin
            if (w.cmd == cli_pkg::CMD_WRITE) mach_cmp[int'(slot)] = w.write_data;
            else rdata = mach_cmp[int'(slot)];
          end
        end
      end
    end

    want = '0;
    want.read_data = rdata;
    want.time_value = time_count;
    for (int h = 0; h < HART_COUNT && h < cli_pkg::OUT_BITS; h++) begin
      want.soft_irq_bits[h] = soft_pending[h];
      want.machine_timer_irq_bits[h] = (time_count >= mach_cmp[h]);
      want.super_timer_irq_bits[h] = (super_cmp[h] != '1) && (time_count >= super_cmp[h]);
    end
    expected_words.insert(expected_words.size(), want);
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Compare one result word with the oldest expectation
  task check_word(cli_pkg::out_word_t got);
    cli_pkg::out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("result word with none expected", got.time_value, '0);
      return;
    end
    want = expected_words.pop_front();
    if (got.read_data !== want.read_data)
      report_mismatch("read_data", got.read_data, want.read_data);
    if (got.soft_irq_bits !== want.soft_irq_bits)
      report_mismatch("soft_irq_bits", 64'(got.soft_irq_bits), 64'(want.soft_irq_bits));
    if (got.machine_timer_irq_bits !== want.machine_timer_irq_bits)
      report_mismatch("machine_timer_irq_bits", 64'(got.machine_timer_irq_bits),
                      64'(want.machine_timer_irq_bits));
    if (got.super_timer_irq_bits !== want.super_timer_irq_bits)
      report_mismatch("super_timer_irq_bits", 64'(got.super_timer_irq_bits),
                      64'(want.super_timer_irq_bits));
    if (got.time_value !== want.time_value)
      report_mismatch("time_value", got.time_value, want.time_value);
  endtask
endclass

module testbench;
  import cli_pkg::*;

  localparam int          IDLE_LIMIT    = 2000;
  localparam int          HOLD_CYCLES   = 60;
  localparam int          END_CYCLES    = 8;
  localparam int          PHASES        = 6;
  localparam logic [63:0] TIMER_OFF     = 64'(SOFT_BYTES);
  localparam logic [63:0] TIME_ADDR_OFF = 64'(SOFT_BYTES) + TIME_OFFSET;
  localparam logic [63:0] REGION_END    = 64'(SOFT_BYTES + TIMER_REGION_BYTES);

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  irq_scoreboard sb;
  bit            hold_req;
  int            hold_left;
  int            rx_cycle;
  int            rx_mode;

  core_local_interruptor #(
    .HARTS             (HART_COUNT),
    .SOFT_REGION_BYTES (SOFT_BYTES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic in_word_t pack_word(logic [1:0] cmd, logic [63:0] addr,
                                         logic [63:0] data, logic [1:0] hart);
    in_word_t w;
    w.cmd = cmd;
    w.address = addr;
    w.write_data = data;
    w.hart_select = hart;
    return w;
  endfunction

  // Random word: mostly mapped slots, often with compare values close to the current time
  function automatic in_word_t make_word();
    in_word_t    w;
    int          pick;
    logic [63:0] base;
    logic [63:0] near_time;
    base = sb.base_addr;
    near_time = sb.time_count + 64'($urandom_range(0, 12)) - 64'd6;
    pick = $urandom_range(0, 99);
    if (pick < 30) w.cmd = CMD_TICK;
    else if (pick < 55) w.cmd = CMD_READ;
    else if (pick < 85) w.cmd = CMD_WRITE;
    else w.cmd = CMD_SUPER;
    w.hart_select = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick < 4) w.write_data = near_time;
    else if (pick == 4) w.write_data = '1;
    else if (pick == 5) w.write_data = '0;
    else w.write_data = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick < 6)
      w.address = base + 64'(4 * $urandom_range(0, 5) + $urandom_range(0, 3));
    else if (pick < 12)
      w.address = base + TIMER_OFF + 64'(8 * $urandom_range(0, 5) + $urandom_range(0, 7));
    else if (pick < 15)
      w.address = base + TIME_ADDR_OFF;
    else if (pick == 15)
      w.address = base + 64'($urandom_range(0, SOFT_BYTES + TIMER_REGION_BYTES - 1));
    else if (pick == 16)
      w.address = base + REGION_END + 64'($urandom_range(0, 7)) - 64'd4;
    else if (pick == 17)
      w.address = base - 64'($urandom_range(1, 8));
    else
      w.address = {$urandom, $urandom};
    return w;
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
  endtask

  // Send random words in bursts; gaps between bursts unless told not to
  task automatic send_random(input int count, input bit no_gaps);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_word(make_word());
        left--;
      end
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted word, then pick the next ready value
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_word);
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (rx_cycle % 4) != 3;
        default: out_ready <= (rx_cycle % 3) == 0;
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_seq
    logic [63:0] phase_base [PHASES];
    logic [63:0] b;
    sb = new();
    phase_base[0] = RESET_BASE;
    phase_base[1] = 64'h0;
    phase_base[2] = '1;
    phase_base[3] = 64'hFFFF_FFFF_FFFF_E000;
    phase_base[4] = {$urandom, $urandom};
    phase_base[5] = RESET_BASE;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // reprogram the base address while the block is empty
      if (p > 0) begin
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= phase_base[p];
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.base_addr = phase_base[p];
      end
      b = phase_base[p];

      if (p == 0) begin
        // directed: each command, slot edges, disabled compare, time wrap
        send_word(pack_word(CMD_TICK, '0, '0, 2'd0));
        send_word(pack_word(CMD_READ, b + TIME_ADDR_OFF, '0, 2'd0));
        send_word(pack_word(CMD_WRITE, b, '1, 2'd1));
        send_word(pack_word(CMD_READ, b, '0, 2'd2));
        send_word(pack_word(CMD_WRITE, b + 64'd12, 64'h1, 2'd3));
        send_word(pack_word(CMD_WRITE, b + 64'd16, '1, 2'd0));
        send_word(pack_word(CMD_READ, b + 64'd16, '0, 2'd0));
        send_word(pack_word(CMD_WRITE, b + TIMER_OFF + 64'd8, 64'd5, 2'd0));
        send_word(pack_word(CMD_WRITE, b + TIMER_OFF + 64'd24, '1, 2'd0));
        send_word(pack_word(CMD_READ, b + TIMER_OFF + 64'd8, '0, 2'd0));
        send_word(pack_word(CMD_READ, b + TIMER_OFF + 64'd32, '0, 2'd0));
        send_word(pack_word(CMD_SUPER, '1, 64'd3, 2'd2));
        send_word(pack_word(CMD_SUPER, '0, '1, 2'd0));
        send_word(pack_word(CMD_WRITE, b + TIME_ADDR_OFF, '1, 2'd0));
        send_word(pack_word(CMD_READ, b + TIME_ADDR_OFF, '0, 2'd0));
        send_word(pack_word(CMD_TICK, '1, '1, 2'd3));
        send_word(pack_word(CMD_WRITE, b + REGION_END, '1, 2'd0));
        send_word(pack_word(CMD_READ, b - 64'd1, '0, 2'd0));
        send_word(pack_word(CMD_READ, b + TIMER_OFF - 64'd1, '0, 2'd0));
        send_word(pack_word(CMD_SUPER, '0, 64'hFFFF_FFFF_FFFF_FFFE, 2'd3));
        send_word(pack_word(CMD_WRITE, b + TIME_ADDR_OFF, 64'hFFFF_FFFF_FFFF_FFFE, 2'd0));
        send_word(pack_word(CMD_TICK, '0, '0, 2'd0));
        send_word(pack_word(CMD_READ, {$urandom, $urandom}, '1, 2'd1));
      end

      // back-pressure: receiver holds off while the sender keeps offering
      if (p == 2) begin
        hold_req = 1'b1;
        send_random(40, 1'b1);
      end
      send_random(160, 1'b0);
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
